@@ hdl/pot_pkg.sv @@
//------------------------------------------------------------------------------
// pot_pkg
// shared types and constants for the pentatope orientation test
//------------------------------------------------------------------------------
`default_nettype none
package pot_pkg;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic start;      // latch query ids and begin
        logic fetch;      // issue a read for vertex fetch_sel
        logic [2:0] fetch_sel;
        logic capture;    // capture read data into slot cap_sel
        logic [2:0] cap_sel;
        logic step;       // one multiply-accumulate step
        logic [5:0] step_idx;
    } pot_cmd_t;

    typedef struct packed {
        logic det_pos;
    } pot_stat_t;
endpackage
`default_nettype wire

@@ hdl/pot_ctrl.sv @@
//------------------------------------------------------------------------------
// pot_ctrl
// sequencer: store writes, five vertex reads, then the product-term loop
//------------------------------------------------------------------------------
`default_nettype none
module pot_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              command,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pot_pkg::pot_cmd_t      cmd
);
    import pot_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_CALC  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;
    localparam logic [5:0] LAST_STEP = 6'd47;

    logic [1:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [5:0] step_reg, step_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready && command == CMD_QUERY)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_FETCH;
                    cnt_next   = 3'd0;
                end
            end
            S_FETCH:
            begin
                // read issued at cnt, captured in the next cycle
                cmd.fetch     = (cnt_reg < 3'd5);
                cmd.fetch_sel = cnt_reg;
                cmd.capture   = (cnt_reg != 3'd0);
                cmd.cap_sel   = cnt_reg - 3'd1;
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = S_CALC;
                    step_next  = 6'd0;
                end
            end
            S_CALC:
            begin
                cmd.step     = 1'b1;
                cmd.step_idx = step_reg;
                step_next    = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

@@ hdl/pot_dp.sv @@
//------------------------------------------------------------------------------
// pot_dp
// vertex memory, edge vectors and the shared-multiplier determinant accumulator
//------------------------------------------------------------------------------
`default_nettype none
module pot_dp #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 32
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [9:0]          vertex_index,
    input  wire logic [31:0]         coord_x,
    input  wire logic [31:0]         coord_y,
    input  wire logic [31:0]         coord_z,
    input  wire logic [31:0]         coord_t,
    input  wire logic [9:0]          id_a,
    input  wire logic [9:0]          id_b,
    input  wire logic [9:0]          id_c,
    input  wire logic [9:0]          id_d,
    input  wire logic [9:0]          id_e,
    input  wire pot_pkg::pot_cmd_t   cmd,
    output pot_pkg::pot_stat_t       stat
);
    import pot_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DB = COORD_BITS + 1;
    localparam int MB = 2 * DB;
    localparam int AB = 4 * DB + 8;

    logic [4*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [4*COORD_BITS-1:0] rd_reg;
    logic                    rd_ok_reg;
    logic [9:0]              ids_reg [5];
    logic signed [COORD_BITS-1:0] v_reg [5][4];
    logic signed [DB-1:0] d [4][4];
    logic [2:0]           pair, sub;
    logic [8:0]           sel;
    logic [1:0]           s0, s1, c0, c1;
    logic                 pneg;
    logic signed [DB:0]   op_a, op_b;
    logic signed [2*DB+1:0] prod;
    logic signed [AB-1:0] addend;
    logic signed [MB-1:0] ma_reg, mb_reg;
    logic signed [AB-1:0] acc_reg;

    function automatic logic idx_ok(input logic [9:0] id);
        idx_ok = (32'(id) < 32'(MAX_VERTICES));
    endfunction

    // vertex memory, single write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en && idx_ok(vertex_index))
            mem[AW'(vertex_index)] <= {coord_t[COORD_BITS-1:0], coord_z[COORD_BITS-1:0],
                                       coord_y[COORD_BITS-1:0], coord_x[COORD_BITS-1:0]};
        if (cmd.fetch)
        begin
            rd_reg    <= mem[AW'(ids_reg[cmd.fetch_sel])];
            rd_ok_reg <= idx_ok(ids_reg[cmd.fetch_sel]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ids_reg[0] <= id_e;
            ids_reg[1] <= id_a;
            ids_reg[2] <= id_b;
            ids_reg[3] <= id_c;
            ids_reg[4] <= id_d;
        end
        if (cmd.capture)
            for (int k = 0; k < 4; k++)
                v_reg[cmd.cap_sel][k] <= rd_ok_reg ?
                    rd_reg[k*COORD_BITS +: COORD_BITS] : '0;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 4; k++)
                d[i][k] = DB'(v_reg[i+1][k]) - DB'(v_reg[0][k]);
    end

    // six row splits, eight steps each: x-y minor of rows s0,s1 (steps 0-1),
    // z-t minor of rows c0,c1 (steps 2-3), then their product limb by limb
    always_comb
    begin
        pair = cmd.step_idx[5:3];
        sub  = cmd.step_idx[2:0];
        case (pair)
            3'd0:    sel = {2'd0, 2'd1, 2'd2, 2'd3, 1'b0};
            3'd1:    sel = {2'd0, 2'd2, 2'd1, 2'd3, 1'b1};
            3'd2:    sel = {2'd0, 2'd3, 2'd1, 2'd2, 1'b0};
            3'd3:    sel = {2'd1, 2'd2, 2'd0, 2'd3, 1'b0};
            3'd4:    sel = {2'd1, 2'd3, 2'd0, 2'd2, 1'b1};
            default: sel = {2'd2, 2'd3, 2'd0, 2'd1, 1'b0};
        endcase
        s0   = sel[8:7];
        s1   = sel[6:5];
        c0   = sel[4:3];
        c1   = sel[2:1];
        pneg = sel[0];
        case (sub)
            3'd0:       op_a = (DB+1)'(d[s0][0]);
            3'd1:       op_a = (DB+1)'(d[s1][0]);
            3'd2:       op_a = (DB+1)'(d[c0][2]);
            3'd3:       op_a = (DB+1)'(d[c1][2]);
            3'd4, 3'd6: op_a = $signed({1'b0, ma_reg[DB-1:0]});
            default:    op_a = (DB+1)'($signed(ma_reg[MB-1:DB]));
        endcase
        case (sub)
            3'd0:       op_b = (DB+1)'(d[s1][1]);
            3'd1:       op_b = (DB+1)'(d[s0][1]);
            3'd2:       op_b = (DB+1)'(d[c1][3]);
            3'd3:       op_b = (DB+1)'(d[c0][3]);
            3'd4, 3'd5: op_b = $signed({1'b0, mb_reg[DB-1:0]});
            default:    op_b = (DB+1)'($signed(mb_reg[MB-1:DB]));
        endcase
        case (sub)
            3'd4:       addend = AB'(prod);
            3'd5, 3'd6: addend = AB'(prod) <<< DB;
            default:    addend = AB'(prod) <<< (2 * DB);
        endcase
    end

    // the one shared multiplier
    assign prod = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            acc_reg <= '0;
        else if (cmd.step)
        begin
            case (sub)
                3'd0:    ma_reg <= MB'(prod);
                3'd1:    ma_reg <= ma_reg - MB'(prod);
                3'd2:    mb_reg <= MB'(prod);
                3'd3:    mb_reg <= mb_reg - MB'(prod);
                default: acc_reg <= pneg ? acc_reg - addend : acc_reg + addend;
            endcase
        end
    end

    assign stat.det_pos = !acc_reg[AB-1] && (acc_reg != '0);
endmodule
`default_nettype wire

@@ hdl/pentatope_orientation_test_top.sv @@
//------------------------------------------------------------------------------
// pentatope_orientation_test_top
// pentatope orientation from a store of 4-d vertices
//------------------------------------------------------------------------------
// A write transaction (command 0) stores one vertex and gives no result, so
// writes can follow back to back. A query transaction (command 1) reads the
// five named vertices one at a time from the vertex memory, then forms the
// 4x4 determinant exactly through one shared signed multiplier: for each of
// the six row splits, two 2x2 minors and then their limb-by-limb product.
// out_valid rises after the last product term is accumulated, and the input
// stays closed from the accepted query until the result is taken.
`default_nettype none
module pentatope_orientation_test_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [9:0]  vertex_index,
    input  wire logic [31:0] coord_x,
    input  wire logic [31:0] coord_y,
    input  wire logic [31:0] coord_z,
    input  wire logic [31:0] coord_t,
    input  wire logic [9:0]  id_a,
    input  wire logic [9:0]  id_b,
    input  wire logic [9:0]  id_c,
    input  wire logic [9:0]  id_d,
    input  wire logic [9:0]  id_e,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_positive
);
    import pot_pkg::*;

    pot_cmd_t  cmd;
    pot_stat_t stat;
    logic      wr_en;

    // store writes go straight through when the front is open
    assign wr_en = in_valid && in_ready && (command == CMD_WRITE);

    pot_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .command(command),
        .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
    );

    pot_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .wr_en(wr_en), .vertex_index(vertex_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .coord_t(coord_t),
        .id_a(id_a), .id_b(id_b), .id_c(id_c), .id_d(id_d), .id_e(id_e),
        .cmd(cmd), .stat(stat)
    );

    // result held stable while out_valid waits
    assign is_positive = stat.det_pos;
endmodule
`default_nettype wire

@@ hdl/pot_checker.sv @@
//------------------------------------------------------------------------------
// pot_checker
// port-level checks for the orientation test
//------------------------------------------------------------------------------
`default_nettype none
module pot_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic command,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic is_positive
);
    import pot_pkg::*;

    // a waiting result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> is_positive == $past(is_positive))
        else $error("result changed while stalled");
    // no new transaction while a result waits
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open with pending result");
    // a query closes the input next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_QUERY) |=> !in_ready)
        else $error("query did not occupy block");
    // a write transaction gives no result
    a_wr: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_WRITE) && !out_valid |=> !out_valid)
        else $error("write produced a result");
endmodule
bind pentatope_orientation_test_top pot_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .out_valid(out_valid), .out_ready(out_ready),
    .is_positive(is_positive)
);
`default_nettype wire
